// ----- hw/rtl/lir_pkg.sv -----
// ----------------------------------------------------------------------------
// lir_pkg
// Shared constants, types and codes for the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int SAMPLE_BITS  = 24;
    localparam int FRAC_BITS    = 24;
    localparam int POS_BITS     = FRAC_BITS + 5;
    localparam int CHCNT_BITS   = 3;
    localparam int MAX_RESULTS  = 16;
    localparam int RES_CNT_BITS = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_BITS = 4;
    localparam int DIFF_BITS    = SAMPLE_BITS + 1;
    localparam int PROD_BITS    = DIFF_BITS + FRAC_BITS + 1;

    localparam logic [POS_BITS-1:0]  POS_ONE    = POS_BITS'(64'd1 << FRAC_BITS);
    localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(64'd1 << (FRAC_BITS - 1));

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_STEP_RATIO    = cfg_idx_t'(0);
    localparam cfg_idx_t REG_CHANNEL_COUNT = cfg_idx_t'(1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } lir_state_t;

    // control word travelling alongside the lane pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } lir_ctl_t;

endpackage

// ----- hw/rtl/lir_lane.sv -----
// ----------------------------------------------------------------------------
// lir_lane
// One channel of the interpolator: registered t*(cur-prev), then rounding
// to nearest (ties upward) and the add of prev.
// ----------------------------------------------------------------------------
module lir_lane
    import lir_pkg::*;
(
    input  logic                          clk,
    input  logic                          adv,
    input  logic                          en,
    input  logic signed [SAMPLE_BITS-1:0] prev,
    input  logic signed [SAMPLE_BITS-1:0] cur,
    input  logic        [FRAC_BITS-1:0]   frac,
    output logic signed [SAMPLE_BITS-1:0] result
);

    logic signed [DIFF_BITS-1:0]   diff;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic                          en_reg;
    logic signed [PROD_BITS-1:0]   rounded;
    logic signed [DIFF_BITS-1:0]   delta;
    logic signed [DIFF_BITS-1:0]   sum;

    assign diff      = DIFF_BITS'(cur) - DIFF_BITS'(prev);
    assign prod_next = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, frac}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            prev_reg <= prev;
            en_reg   <= en;
        end
    end

    assign rounded = prod_reg + $signed(ROUND_HALF);
    assign delta   = DIFF_BITS'(rounded >>> FRAC_BITS);
    // result always lies between prev and cur, so the top bit drops safely
    assign sum     = DIFF_BITS'(prev_reg) + delta;
    assign result  = en_reg ? sum[SAMPLE_BITS-1:0] : '0;

endmodule

// ----- hw/rtl/lir_merge.sv -----
// ----------------------------------------------------------------------------
// lir_merge
// Gathers the lane results into one output frame register and handles the
// output handshake; tells the pipeline when it may advance.
// ----------------------------------------------------------------------------
module lir_merge
    import lir_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lir_ctl_t                      ctl,
    input  logic signed [SAMPLE_BITS-1:0] lane_res [MAX_CHANNELS],
    input  logic                          out_stall,
    output logic                          adv,
    output logic                          out_valid,
    output logic                          out_last,
    output logic signed [SAMPLE_BITS-1:0] out_smp [MAX_CHANNELS]
);

    logic                          valid_reg;
    logic                          last_reg;
    logic signed [SAMPLE_BITS-1:0] smp_reg [MAX_CHANNELS];

    assign adv = !(valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && ctl.valid)
        begin
            last_reg <= ctl.last;
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                smp_reg[c] <= lane_res[c];
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_last  = last_reg;
    assign out_smp   = smp_reg;

endmodule

// ----- hw/rtl/linear_interp_resampler_unit.sv -----
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit
// Four-channel linear interpolation sample-rate converter.
// ----------------------------------------------------------------------------
// An input word is one frame. While the read position is below 1.0 the unit
// emits one output frame per cycle unless the output side stalls, all channel
// lanes multiplying in parallel, then advances the position by step_ratio; at
// most 16 frames come from one input. A frame holds the input side through
// the accept, one issue per output through the shared position sequencer and
// a closing step, plus any output stalls. Results pass the lane product and
// merge output registers. With channel_count zero a word is taken and dropped.
// Any configuration write clears the previous frame and sets the position
// to 1.0; writes are to be made while the unit is idle.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit
    import lir_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [POS_BITS-1:0]           cfg_data,
    // input frames
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] in_ch0,
    input  logic signed [SAMPLE_BITS-1:0] in_ch1,
    input  logic signed [SAMPLE_BITS-1:0] in_ch2,
    input  logic signed [SAMPLE_BITS-1:0] in_ch3,
    // output frames
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_ch0,
    output logic signed [SAMPLE_BITS-1:0] out_ch1,
    output logic signed [SAMPLE_BITS-1:0] out_ch2,
    output logic signed [SAMPLE_BITS-1:0] out_ch3,
    output logic                          last_of_run
);

    lir_state_t                    state_reg, state_next;
    logic [POS_BITS-1:0]           pos_reg, pos_next;
    logic [RES_CNT_BITS-1:0]       cnt_reg, cnt_next;
    logic [POS_BITS-1:0]           step_reg;
    logic [CHCNT_BITS-1:0]         chcnt_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] cur_reg  [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] in_frame [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] lane_res [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] out_smp  [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]       lane_en;

    lir_ctl_t                      ctl_issue;
    lir_ctl_t                      ctl_s1_reg;

    logic                          cfg_wr;
    logic                          in_acc;
    logic                          adv;
    logic                          more;
    logic                          issue;
    logic                          finish;
    logic                          start;
    logic [POS_BITS:0]             pos_sum;
    logic [POS_BITS-1:0]           pos_sat;

    assign in_frame[0] = in_ch0;
    assign in_frame[1] = in_ch1;
    assign in_frame[2] = in_ch2;
    assign in_frame[3] = in_ch3;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign in_acc    = in_valid && !in_stall;

    assign pos_sum = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_sat = pos_sum[POS_BITS] ? '1 : pos_sum[POS_BITS-1:0];
    assign more    = (pos_reg < POS_ONE) && (cnt_reg < RES_CNT_BITS'(MAX_RESULTS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (chcnt_reg != '0))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall = 1'b1;
        start    = 1'b0;
        issue    = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                start    = in_acc && (chcnt_reg != '0);
            end
            ST_RUN:
            begin
                issue  = more && adv;
                finish = !more;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign ctl_issue.valid = issue;
    assign ctl_issue.last  = (pos_sat >= POS_ONE)
                          || (cnt_reg == RES_CNT_BITS'(MAX_RESULTS - 1));

    always_comb
    begin
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = '0;
        end
        if (issue)
        begin
            pos_next = pos_sat;
            cnt_next = cnt_reg + RES_CNT_BITS'(1);
        end
        else if (finish)
        begin
            // clamp at zero when the run was cut short
            pos_next = (pos_reg >= POS_ONE) ? pos_reg - POS_ONE : '0;
        end
        if (cfg_wr)
        begin
            pos_next = POS_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= POS_ONE;
            cnt_reg    <= '0;
            step_reg   <= POS_ONE;
            chcnt_reg  <= '0;
            ctl_s1_reg <= '0;
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                prev_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            if (adv)
            begin
                ctl_s1_reg <= ctl_issue;
            end
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_STEP_RATIO:    step_reg  <= cfg_data;
                    REG_CHANNEL_COUNT: chcnt_reg <= cfg_data[CHCNT_BITS-1:0];
                    default:           ;
                endcase
                for (int c = 0; c < MAX_CHANNELS; c++)
                begin
                    prev_reg[c] <= '0;
                end
            end
            else if (finish)
            begin
                prev_reg <= cur_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg <= in_frame;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_CHANNELS; g++)
        begin : g_lane
            // channels at or above the count (clamped or not) read as zero
            assign lane_en[g] = CHCNT_BITS'(g) < chcnt_reg;

            lir_lane u_lane (
                .clk    (clk),
                .adv    (adv),
                .en     (lane_en[g]),
                .prev   (prev_reg[g]),
                .cur    (cur_reg[g]),
                .frac   (pos_reg[FRAC_BITS-1:0]),
                .result (lane_res[g])
            );
        end
    endgenerate

    lir_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_s1_reg),
        .lane_res  (lane_res),
        .out_stall (out_stall),
        .adv       (adv),
        .out_valid (out_valid),
        .out_last  (last_of_run),
        .out_smp   (out_smp)
    );

    assign out_ch0 = out_smp[0];
    assign out_ch1 = out_smp[1];
    assign out_ch2 = out_smp[2];
    assign out_ch3 = out_smp[3];

endmodule

// ----- tb/sv/resample_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// resample_checker
// Watches the register, input and output channels of the resampler, works
// out the interpolated frames each accepted input word should give and
// compares every accepted output word against the oldest one still due.
// ----------------------------------------------------------------------------
module resample_checker
    import lir_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [POS_BITS-1:0]           cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] in_ch0,
    input  logic signed [SAMPLE_BITS-1:0] in_ch1,
    input  logic signed [SAMPLE_BITS-1:0] in_ch2,
    input  logic signed [SAMPLE_BITS-1:0] in_ch3,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [SAMPLE_BITS-1:0] out_ch0,
    input  logic signed [SAMPLE_BITS-1:0] out_ch1,
    input  logic signed [SAMPLE_BITS-1:0] out_ch2,
    input  logic signed [SAMPLE_BITS-1:0] out_ch3,
    input  logic                          last_of_run,
    output int                            error_count,
    output int                            pending,
    output int                            frames_in,
    output int                            frames_out,
    output int                            reg_writes
);

    localparam longint POS_UNITY = longint'(POS_ONE);
    localparam longint POS_LIMIT = (longint'(1) << POS_BITS) - 1;

    typedef logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] lanes_t;

    typedef struct packed {
        lanes_t lanes;
        logic   last;
    } lerp_frame_t;

    lerp_frame_t                   lerp_due[$];
    logic [POS_BITS-1:0]           step_ratio;
    logic [POS_BITS-1:0]           read_pos;
    logic [CHCNT_BITS-1:0]         chan_count;
    logic signed [SAMPLE_BITS-1:0] prev_lane [MAX_CHANNELS];
    lerp_frame_t                   got;
    lerp_frame_t                   want;

    // prev + t*(cur - prev), product rounded half up
    function automatic logic [SAMPLE_BITS-1:0] lerp_lane(input longint prev,
                                                         input longint cur,
                                                         input longint t);
        longint acc;
        acc = (cur - prev) * t + (longint'(1) << (FRAC_BITS - 1));
        return SAMPLE_BITS'(prev + (acc >>> FRAC_BITS));
    endfunction

    task automatic restart_lanes();
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            prev_lane[c] = '0;
        end
        read_pos = POS_ONE;
    endtask

    task automatic predict_frames(input lanes_t cur);
        int          lanes_on;
        int          n;
        longint      pos;
        lerp_frame_t f;
        lanes_on = (chan_count > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_count);
        if (lanes_on == 0)
            return;
        pos = longint'(read_pos);
        n   = 0;
        while (pos < POS_UNITY && n < MAX_RESULTS)
        begin
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                if (c < lanes_on)
                    f.lanes[c] = lerp_lane(longint'(prev_lane[c]),
                                           longint'($signed(cur[c])), pos);
                else
                    f.lanes[c] = '0;
            end
            f.last = 1'b0;
            lerp_due.insert(lerp_due.size(), f);
            n++;
            pos += longint'(step_ratio);
            if (pos > POS_LIMIT)
                pos = POS_LIMIT;
        end
        if (n > 0)
        begin
            f      = lerp_due[lerp_due.size() - 1];
            f.last = 1'b1;
            lerp_due[lerp_due.size() - 1] = f;
        end
        // position clamps at zero when emission was cut short
        read_pos = (pos >= POS_UNITY) ? POS_BITS'(pos - POS_UNITY) : '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            prev_lane[c] = $signed(cur[c]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lerp_due.delete();
            step_ratio  = POS_ONE;
            chan_count  = '0;
            restart_lanes();
            error_count = 0;
            pending     = 0;
            frames_in   = 0;
            frames_out  = 0;
            reg_writes  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                frames_out++;
                got.lanes = {out_ch3, out_ch2, out_ch1, out_ch0};
                got.last  = last_of_run;
                if (lerp_due.size() == 0)
                begin
                    error_count++;
                    $display("%0t: output word with none due: %h %h %h %h last %b",
                             $time, out_ch0, out_ch1, out_ch2, out_ch3, last_of_run);
                end
                else
                begin
                    want = lerp_due.pop_front();
                    for (int c = 0; c < MAX_CHANNELS; c++)
                    begin
                        if (got.lanes[c] !== want.lanes[c])
                        begin
                            error_count++;
                            $display("%0t: out_ch%0d expected %h, got %h",
                                     $time, c, want.lanes[c], got.lanes[c]);
                        end
                    end
                    if (got.last !== want.last)
                    begin
                        error_count++;
                        $display("%0t: last_of_run expected %b, got %b",
                                 $time, want.last, got.last);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                if (cfg_index == REG_STEP_RATIO)
                    step_ratio = cfg_data;
                else if (cfg_index == REG_CHANNEL_COUNT)
                    chan_count = cfg_data[CHCNT_BITS-1:0];
                // any write, known index or not, restarts
                restart_lanes();
            end
            if (in_valid && !in_stall)
            begin
                frames_in++;
                predict_frames({in_ch3, in_ch2, in_ch1, in_ch0});
            end
            pending = lerp_due.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the linear interpolation resampler: a directed pass over
// step and channel-count corners, then randomised settings with random
// frames, random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb;
    import lir_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int RANDOM_FRAMES = 470;

    localparam logic [SAMPLE_BITS-1:0] S_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] S_ZERO = '0;
    localparam logic [SAMPLE_BITS-1:0] S_NEG1 = '1;
    localparam logic [SAMPLE_BITS-1:0] S_ALT5 = {(SAMPLE_BITS/2){2'b01}};
    localparam logic [SAMPLE_BITS-1:0] S_ALTA = {(SAMPLE_BITS/2){2'b10}};

    localparam logic [POS_BITS-1:0] STEP_UNIT    = POS_ONE;
    localparam logic [POS_BITS-1:0] STEP_SIXTEEN = POS_ONE >> 4;
    localparam logic [POS_BITS-1:0] STEP_TOP     = POS_ONE << 4;
    localparam logic [POS_BITS-1:0] STEP_FULL    = '1;
    localparam cfg_idx_t            REG_SPARE_LO = REG_CHANNEL_COUNT + 1'b1;
    localparam cfg_idx_t            REG_SPARE_HI = '1;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
    logic [POS_BITS-1:0]           cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] in_ch0    = '0;
    logic signed [SAMPLE_BITS-1:0] in_ch1    = '0;
    logic signed [SAMPLE_BITS-1:0] in_ch2    = '0;
    logic signed [SAMPLE_BITS-1:0] in_ch3    = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] out_ch0;
    logic signed [SAMPLE_BITS-1:0] out_ch1;
    logic signed [SAMPLE_BITS-1:0] out_ch2;
    logic signed [SAMPLE_BITS-1:0] out_ch3;
    logic                          last_of_run;

    int   error_count;
    int   pending;
    int   frames_in;
    int   frames_out;
    int   reg_writes;
    int   settings = 0;
    int   cycles   = 0;
    logic calm     = 1'b0;

    linear_interp_resampler_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_ch0      (in_ch0),
        .in_ch1      (in_ch1),
        .in_ch2      (in_ch2),
        .in_ch3      (in_ch3),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_ch0     (out_ch0),
        .out_ch1     (out_ch1),
        .out_ch2     (out_ch2),
        .out_ch3     (out_ch3),
        .last_of_run (last_of_run)
    );

    resample_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_ch0      (in_ch0),
        .in_ch1      (in_ch1),
        .in_ch2      (in_ch2),
        .in_ch3      (in_ch3),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_ch0     (out_ch0),
        .out_ch1     (out_ch1),
        .out_ch2     (out_ch2),
        .out_ch3     (out_ch3),
        .last_of_run (last_of_run),
        .error_count (error_count),
        .pending     (pending),
        .frames_in   (frames_in),
        .frames_out  (frames_out),
        .reg_writes  (reg_writes)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 20);
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [POS_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drop valid, wait out every due word and any dropped-word tail
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_frame(input logic [SAMPLE_BITS-1:0] s0,
                              input logic [SAMPLE_BITS-1:0] s1,
                              input logic [SAMPLE_BITS-1:0] s2,
                              input logic [SAMPLE_BITS-1:0] s3);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_ch0   <= s0;
        in_ch1   <= s1;
        in_ch2   <= s2;
        in_ch3   <= s3;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic set_rate(input logic [POS_BITS-1:0] step,
                            input logic [CHCNT_BITS-1:0] chans);
        quiesce();
        write_reg(REG_STEP_RATIO, step);
        write_reg(REG_CHANNEL_COUNT, POS_BITS'(chans));
        settings++;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] draw_sample();
        case ($urandom_range(19))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return S_ZERO;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [POS_BITS-1:0] draw_step();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return POS_BITS'($urandom_range(0, int'(STEP_SIXTEEN) - 1));
        else if (pick < 8)
            return STEP_FULL;
        else if (pick < 11)
            return STEP_TOP;
        else if (pick < 14)
            return STEP_SIXTEEN;
        else if (pick < 55)
            return POS_BITS'($urandom_range(int'(STEP_SIXTEEN), int'(STEP_UNIT)));
        else if (pick < 85)
            return POS_BITS'($urandom_range(int'(STEP_UNIT), 4 * int'(STEP_UNIT)));
        return POS_BITS'($urandom_range(4 * int'(STEP_UNIT), int'(STEP_TOP)));
    endfunction

    function automatic logic [CHCNT_BITS-1:0] draw_chans();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        else if (pick < 20)
            return CHCNT_BITS'($urandom_range(MAX_CHANNELS + 1, (1 << CHCNT_BITS) - 1));
        return CHCNT_BITS'($urandom_range(1, MAX_CHANNELS));
    endfunction

    initial
    begin
        logic [POS_BITS-1:0]   step;
        logic [CHCNT_BITS-1:0] chans;
        int                    counted;
        int                    burst;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // unity step: output equals the previous frame
        set_rate(STEP_UNIT, CHCNT_BITS'(MAX_CHANNELS));
        send_frame(S_MAX, S_MIN, S_ZERO, S_NEG1);
        send_frame(S_MIN, S_MAX, S_ALT5, S_ALTA);
        send_frame(S_MAX, S_MIN, S_ALTA, S_ALT5);
        // odd step near half, full-scale swings to exercise rounding
        set_rate(STEP_UNIT / 2 + 29'd4661, 3'd3);
        send_frame(S_MIN, S_MAX, S_NEG1, S_ZERO);
        send_frame(S_MAX, S_MIN, S_ZERO, S_NEG1);
        send_frame(S_NEG1, S_ZERO, S_MAX, S_MIN);
        // sixteen words per frame, the most allowed
        set_rate(STEP_SIXTEEN, 3'd2);
        send_frame(S_MAX, S_MIN, S_ZERO, S_ZERO);
        send_frame(S_MIN, S_MAX, S_ZERO, S_ZERO);
        // zero and tiny steps hit the word cap; count above four clamps
        set_rate('0, 3'd7);
        send_frame(S_MAX, S_MIN, S_ALT5, S_ALTA);
        send_frame(S_MIN, S_MAX, S_ALTA, S_ALT5);
        set_rate(29'd12345, 3'd5);
        send_frame(S_MAX, S_MIN, S_ALT5, S_NEG1);
        send_frame(S_MIN, S_MAX, S_ZERO, S_ALTA);
        // biggest step saturates the position
        set_rate(STEP_FULL, 3'd1);
        send_frame(S_MAX, S_MIN, S_ZERO, S_ZERO);
        send_frame(S_MIN, S_MAX, S_ZERO, S_ZERO);
        send_frame(S_MAX, S_ZERO, S_ZERO, S_ZERO);
        set_rate(STEP_TOP, 3'd4);
        send_frame(S_MAX, S_MIN, S_ALT5, S_ALTA);
        send_frame(S_MIN, S_MAX, S_ALTA, S_ALT5);
        // channel count zero drops words
        set_rate(STEP_UNIT / 4, '0);
        send_frame(S_MAX, S_MIN, S_ALT5, S_ALTA);
        send_frame(S_MIN, S_MAX, S_ALTA, S_ALT5);
        // write to an unlisted index restarts only
        set_rate(STEP_UNIT / 4 * 3, 3'd4);
        send_frame(S_MAX, S_MAX, S_MIN, S_MIN);
        send_frame(S_MIN, S_NEG1, S_MAX, S_ZERO);
        quiesce();
        write_reg(REG_SPARE_HI, STEP_FULL);
        send_frame(S_ALT5, S_ALTA, S_MAX, S_MIN);
        send_frame(S_ALTA, S_ALT5, S_MIN, S_MAX);

        counted = 0;
        while (counted < RANDOM_FRAMES)
        begin
            step  = draw_step();
            chans = draw_chans();
            quiesce();
            if ($urandom_range(4) == 0)
                write_reg(cfg_idx_t'($urandom_range(int'(REG_SPARE_LO), int'(REG_SPARE_HI))),
                          POS_BITS'($urandom));
            if ($urandom_range(1))
            begin
                write_reg(REG_STEP_RATIO, step);
                write_reg(REG_CHANNEL_COUNT, POS_BITS'(chans));
            end
            else
            begin
                write_reg(REG_CHANNEL_COUNT, POS_BITS'(chans));
                write_reg(REG_STEP_RATIO, step);
            end
            settings++;
            burst = (chans == 0) ? 6 : $urandom_range(20, 60);
            if (chans != 0 && burst > RANDOM_FRAMES - counted)
                burst = RANDOM_FRAMES - counted;
            repeat (burst)
            begin
                calm = (counted >= 200 && counted < 300);
                send_frame(draw_sample(), draw_sample(), draw_sample(), draw_sample());
                if (chans != 0)
                    counted++;
            end
        end
        calm = 1'b0;
        quiesce();

        $display("tb: %0d frames in, %0d frames out, %0d register writes",
                 frames_in, frames_out, reg_writes);
        $display("tb: %0d rate/channel settings incl. zero, clamped and capped steps",
                 settings);
        if (pending != 0)
            $display("tb: %0d expected words never came", pending);
        if (error_count == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/lir_pkg.sv
hw/rtl/lir_lane.sv
hw/rtl/lir_merge.sv
hw/rtl/linear_interp_resampler_unit.sv
tb/sv/resample_checker.sv
tb/sv/tb.sv
